FILE: rtl/core/rgpw_pkg.sv
// package: constants and types for the rotated grid pixel writer
`timescale 1ns / 1ps
package rgpw_pkg;
    localparam int FRAME_WIDTH_DEF  = 1024;
    localparam int FRAME_HEIGHT_DEF = 1024;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_EXTENT_X  = 3'd2,
        REG_EXTENT_Y  = 3'd3,
        REG_CELL_CNT  = 3'd4,
        REG_THICKNESS = 3'd5,
        REG_ROTATION  = 3'd6,
        REG_COLOR     = 3'd7
    } t_reg_idx;
endpackage

FILE: rtl/core/rgpw_if.sv
// interfaces: input pixel channel and output write channel
`timescale 1ns / 1ps
interface rgpw_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    modport source (output valid, pixel_x, pixel_y, input ready);
    modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface rgpw_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] write_x;
    logic [11:0] write_y;
    logic [23:0] write_color;
    logic        last_write;
    modport source (output valid, write_x, write_y, write_color, last_write, input ready);
    modport sink   (input valid, write_x, write_y, write_color, last_write, output ready);
endinterface

FILE: rtl/core/rgpw_divu.sv
// pipelined unsigned divider: 12-bit dividend by 12-bit divisor, radix 2, one bit a stage
`timescale 1ns / 1ps
module rgpw_divu
    import rgpw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [11:0] i_num,
    input  logic [11:0] i_den,
    output logic [11:0] o_rem
);
    // r_rem[k] holds partial remainder after k quotient bits
    logic [12:0] r_rem [0:12];
    logic [11:0] r_num [0:12];
    logic [11:0] r_den [0:12];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_num[0] <= i_num;
            r_den[0] <= i_den;
        end
    end

    for (genvar k = 0; k < 12; k++) begin : g_step
        logic [12:0] n_sh;
        logic [12:0] n_sub;
        assign n_sh  = {r_rem[k][11:0], r_num[k][11-k]};
        assign n_sub = n_sh - {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_sub[12] ? n_sh : n_sub;
                r_num[k+1] <= r_num[k];
                r_den[k+1] <= r_den[k];
            end
        end
    end

    assign o_rem = r_rem[12][11:0];
endmodule

FILE: rtl/core/rotated_grid_pixel_writer.sv
// top level: grid test, rotation and neighbour write sequencing
// throughput: one item per cycle into the pipeline when not stalled; the output side
// issues one write per cycle while the receiver is ready, so an item causing n writes
// (up to five) holds the input until its last write is taken
// cell size comes from a serial divider, input held off while it runs after reset
// or a config write; offset modulo from a 12-stage pipelined divider per axis
// reset: synchronous active low; registers return to defaults and the pipeline empties
`timescale 1ns / 1ps
module rotated_grid_pixel_writer
    import rgpw_pkg::*;
#(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rgpw_in_if.sink               in_ch,
    rgpw_out_if.source            out_ch
);
    localparam int NST = 17;
    localparam logic signed [31:0] FW_Q = 32'(FRAME_WIDTH) <<< 15;
    localparam logic signed [31:0] FH_Q = 32'(FRAME_HEIGHT) <<< 15;
    localparam logic signed [31:0] ONE_Q = 32'sd32768;

    logic [11:0] r_ox, r_oy, r_ex, r_ey;
    logic [8:0]  r_cnt;
    logic [7:0]  r_t;
    logic [31:0] r_rot;
    logic [23:0] r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= '0; r_oy <= '0; r_ex <= 12'd256; r_ey <= 12'd256;
            r_cnt <= 9'd8; r_t <= 8'd1; r_rot <= 32'h4000_0000; r_col <= 24'hFF_FFFF;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ORIGIN_X:  r_ox  <= i_cfg_data[11:0];
                REG_ORIGIN_Y:  r_oy  <= i_cfg_data[11:0];
                REG_EXTENT_X:  r_ex  <= i_cfg_data[11:0];
                REG_EXTENT_Y:  r_ey  <= i_cfg_data[11:0];
                REG_CELL_CNT:  r_cnt <= i_cfg_data[8:0];
                REG_THICKNESS: r_t   <= i_cfg_data[7:0];
                REG_ROTATION:  r_rot <= i_cfg_data;
                REG_COLOR:     r_col <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // cell size per axis; the user must keep config static while items are in flight (the block
    // does not enforce it), and the input is held off until the divider has settled
    logic [11:0] cnt12, csx_rem_unused, csy_rem_unused;
    logic [11:0] r_qx, r_qy, r_rx, r_ry;
    logic [3:0]  r_div_cnt;
    logic        r_div_busy;
    logic [8:0]  r_cnt_q;
    assign cnt12 = (r_cnt == 9'd0) ? 12'd1 : {3'd0, r_cnt};
    assign csx_rem_unused = r_rx;
    assign csy_rem_unused = r_ry;

    // serial restoring divide of extents by count, restarted on any config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= '0;
            r_qx <= '0; r_qy <= '0; r_rx <= '0; r_ry <= '0;
            r_cnt_q <= '0;
        end else if (r_div_busy) begin
            logic [12:0] sx, sy, dx, dy;
            sx = {r_rx, r_ex[4'd11 - r_div_cnt]};
            sy = {r_ry, r_ey[4'd11 - r_div_cnt]};
            dx = sx - {1'b0, cnt12};
            dy = sy - {1'b0, cnt12};
            r_rx <= dx[12] ? sx[11:0] : dx[11:0];
            r_ry <= dy[12] ? sy[11:0] : dy[11:0];
            r_qx <= {r_qx[10:0], ~dx[12]};
            r_qy <= {r_qy[10:0], ~dy[12]};
            r_div_cnt <= r_div_cnt + 4'd1;
            if (r_div_cnt == 4'd11) r_div_busy <= 1'b0;
            r_cnt_q <= cnt12[8:0];
        end
    end

    logic [11:0] cell_x, cell_y;
    assign cell_x = (r_qx == 12'd0) ? 12'd1 : r_qx;
    assign cell_y = (r_qy == 12'd0) ? 12'd1 : r_qy;

    // pipeline control
    logic        adv;
    logic        r_v [0:NST];
    logic [11:0] r_px [0:NST];
    logic [11:0] r_py [0:NST];
    logic        r_inb [0:NST];

    assign in_ch.ready = adv && !r_div_busy;
    // mark stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NST; k++) r_v[k] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= in_ch.valid && !r_div_busy;
            for (int k = 1; k <= NST; k++) r_v[k] <= r_v[k-1];
        end
    end

    logic [13:0] limx, limy;
    assign limx = 14'(r_ox) + 14'(r_ex) + 14'(r_t);
    assign limy = 14'(r_oy) + 14'(r_ey) + 14'(r_t);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_px[0] <= in_ch.pixel_x;
            r_py[0] <= in_ch.pixel_y;
            r_inb[0] <= (in_ch.pixel_x >= r_ox) && (14'(in_ch.pixel_x) < limx)
                      && (in_ch.pixel_y >= r_oy) && (14'(in_ch.pixel_y) < limy);
            for (int k = 1; k <= NST; k++) begin
                r_px[k] <= r_px[k-1];
                r_py[k] <= r_py[k-1];
                r_inb[k] <= r_inb[k-1];
            end
        end
    end

    // stages 1..12: offset modulo cell size (offset is nonnegative when in bounds)
    logic [11:0] offx, offy, modx, mody;
    assign offx = r_px[0] - r_ox;
    assign offy = r_py[0] - r_oy;
    rgpw_divu u_modx (.i_clk, .i_en(adv), .i_num(offx), .i_den(cell_x), .o_rem(modx));
    rgpw_divu u_mody (.i_clk, .i_en(adv), .i_num(offy), .i_den(cell_y), .o_rem(mody));

    // stage 13: grid decision and half-pixel offsets
    logic               r_hit;
    logic signed [14:0] r_dx, r_dy;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hit <= r_inb[13] && ((modx <= 12'(r_t)) || (mody <= 12'(r_t)));
            r_dx  <= 15'({r_px[13], 1'b0}) - 15'(r_ex) - 15'({r_ox, 1'b0});
            r_dy  <= 15'({r_py[13], 1'b0}) - 15'(r_ey) - 15'({r_oy, 1'b0});
        end
    end

    // stage 14: products
    logic signed [15:0] cs, sn;
    assign cs = r_rot[31:16];
    assign sn = r_rot[15:0];
    logic signed [30:0] r_cdx, r_sdy, r_sdx, r_cdy;
    logic               r_hit2;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cdx <= cs * r_dx; r_sdy <= sn * r_dy;
            r_sdx <= sn * r_dx; r_cdy <= cs * r_dy;
            r_hit2 <= r_hit;
        end
    end

    // stage 15: sums
    logic signed [31:0] r_X, r_Y;
    logic               r_hit3;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_X <= 32'(r_cdx) - 32'(r_sdy) + (32'(14'(r_ex) + 14'({r_ox, 1'b0})) <<< 14);
            r_Y <= 32'(r_sdx) + 32'(r_cdy) + (32'(14'(r_ey) + 14'({r_oy, 1'b0})) <<< 14);
            r_hit3 <= r_hit2;
        end
    end

    // stage 16: frame checks
    logic        r_go, r_up, r_dn;
    logic [11:0] r_xi, r_yi;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_go <= r_hit3 && (r_X > 0) && (r_X < FW_Q) && (r_Y > 0) && (r_Y < FH_Q);
            r_up <= (r_X + ONE_Q < FW_Q) && (r_Y + ONE_Q < FH_Q);
            r_dn <= (r_X - ONE_Q > 0) && (r_Y - ONE_Q > 0);
            r_xi <= r_X[26:15];
            r_yi <= r_Y[26:15];
        end
    end

    // write sequencer: holds one item and steps through its writes
    logic        r_busy;
    logic [2:0]  r_idx;
    logic [4:0]  r_mask;
    logic [11:0] r_cx, r_cy;
    logic [4:0]  nmask;
    logic        out_take;
    assign out_take = out_ch.valid && out_ch.ready;
    // mask bits: centre, below, right, above, left
    assign nmask = {r_dn, r_dn, r_up, r_up, 1'b1};

    logic [4:0] rem_mask;
    assign rem_mask = r_mask & ~((5'd1 << (r_idx + 3'd1)) - 5'd1);
    // pipeline can advance when the sequencer is empty or finishing
    assign adv = !r_busy || (out_take && rem_mask == 5'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx <= '0;
            r_mask <= '0;
        end else if (adv) begin
            r_busy <= r_v[NST] && r_go;
            r_idx <= '0;
            r_mask <= nmask;
            r_cx <= r_xi;
            r_cy <= r_yi;
        end else if (out_take) begin
            if (rem_mask[1]) r_idx <= 3'd1;
            else if (rem_mask[2]) r_idx <= 3'd2;
            else if (rem_mask[3]) r_idx <= 3'd3;
            else r_idx <= 3'd4;
        end
    end

    assign out_ch.valid = r_busy;
    assign out_ch.write_color = r_col;
    assign out_ch.last_write = (rem_mask == 5'd0);
    always_comb begin
        out_ch.write_x = r_cx;
        out_ch.write_y = r_cy;
        case (r_idx)
            3'd1: out_ch.write_y = r_cy + 12'd1;
            3'd2: out_ch.write_x = r_cx + 12'd1;
            3'd3: out_ch.write_y = r_cy - 12'd1;
            3'd4: out_ch.write_x = r_cx - 12'd1;
            default: ;
        endcase
    end

    logic unused_ok;
    assign unused_ok = ^{csx_rem_unused, csy_rem_unused, r_cnt_q, r_div_busy,
                         r_px[NST], r_py[NST], r_inb[NST],
                         r_px[16], r_py[16]};

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(r_idx))
        else $error("write dropped under stall");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && !out_ch.last_write |=> out_ch.valid)
        else $error("item ended before last write");
    a_no_adv_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !out_take |-> !adv)
        else $error("pipeline advanced over held item");
endmodule

FILE: test/rgpw_checker.sv
// checker: predicts grid pixel writes from the observed items and compares the write stream
`timescale 1ns / 1ps
module rgpw_checker
    import rgpw_pkg::*;
#(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rgpw_in_if                    in_w,
    rgpw_out_if                   out_w,
    output int                    o_fail_count,
    output int                    o_pending
);
    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [23:0] color;
        logic        last;
    } t_pix_write;

    t_pix_write pending_writes[$];

    logic [11:0] org_x, org_y, ext_x, ext_y;
    logic [8:0]  cells;
    logic [7:0]  thick;
    logic [31:0] rot;
    logic [23:0] colour;

    function automatic bit on_grid_line(longint p, longint org, longint ext, longint cnt,
                                        longint t);
        longint cell_sz;
        cell_sz = ext / cnt;
        if (cell_sz < 1) cell_sz = 1;
        return ((p - org) % cell_sz) <= t;
    endfunction

    task automatic push_write(longint x, longint y, bit last);
        t_pix_write w;
        w.x     = x[11:0];
        w.y     = y[11:0];
        w.color = colour;
        w.last  = last;
        pending_writes.push_back(w);
    endtask

    task automatic predict_writes(logic [11:0] pix_x, logic [11:0] pix_y);
        longint px, py, ox, oy, ex, ey, t, cnt, c, s, dx, dy, xx, yy, xi, yi, one, fw, fh;
        bit hi_ok, lo_ok;
        px  = pix_x;
        py  = pix_y;
        ox  = org_x;
        oy  = org_y;
        ex  = ext_x;
        ey  = ext_y;
        t   = thick;
        cnt = (cells == 0) ? 1 : cells;
        c   = longint'($signed(rot[31:16]));
        s   = longint'($signed(rot[15:0]));
        one = 32768;
        fw  = longint'(FRAME_WIDTH) * one;
        fh  = longint'(FRAME_HEIGHT) * one;
        if (px < ox || px > ox + ex + t - 1 || py < oy || py > oy + ey + t - 1) return;
        if (!on_grid_line(py, oy, ey, cnt, t) && !on_grid_line(px, ox, ex, cnt, t)) return;
        dx = 2 * px - ex - 2 * ox;
        dy = 2 * py - ey - 2 * oy;
        xx = c * dx - s * dy + (ex + 2 * ox) * 16384;
        yy = s * dx + c * dy + (ey + 2 * oy) * 16384;
        if (!(xx > 0 && xx < fw && yy > 0 && yy < fh)) return;
        xi = xx / one;
        yi = yy / one;
        hi_ok = (xx + one < fw) && (yy + one < fh);
        lo_ok = (xx - one > 0) && (yy - one > 0);
        push_write(xi, yi, !hi_ok && !lo_ok);
        if (hi_ok) begin
            push_write(xi, yi + 1, 1'b0);
            push_write(xi + 1, yi, !lo_ok);
        end
        if (lo_ok) begin
            push_write(xi, yi - 1, 1'b0);
            push_write(xi - 1, yi, 1'b1);
        end
    endtask

    always @(posedge i_clk) begin
        t_pix_write want;
        if (!i_rst_n) begin
            org_x  <= 12'd0;
            org_y  <= 12'd0;
            ext_x  <= 12'd256;
            ext_y  <= 12'd256;
            cells  <= 9'd8;
            thick  <= 8'd1;
            rot    <= 32'h4000_0000;
            colour <= 24'hFF_FFFF;
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_ORIGIN_X:  org_x  <= i_cfg_data[11:0];
                    REG_ORIGIN_Y:  org_y  <= i_cfg_data[11:0];
                    REG_EXTENT_X:  ext_x  <= i_cfg_data[11:0];
                    REG_EXTENT_Y:  ext_y  <= i_cfg_data[11:0];
                    REG_CELL_CNT:  cells  <= i_cfg_data[8:0];
                    REG_THICKNESS: thick  <= i_cfg_data[7:0];
                    REG_ROTATION:  rot    <= i_cfg_data;
                    REG_COLOR:     colour <= i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (in_w.valid && in_w.ready) predict_writes(in_w.pixel_x, in_w.pixel_y);
            if (out_w.valid && out_w.ready) begin
                if (pending_writes.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected write x=%0d y=%0d colour=%h last=%b",
                                 out_w.write_x, out_w.write_y, out_w.write_color,
                                 out_w.last_write);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = pending_writes.pop_front();
                    if (out_w.write_x !== want.x || out_w.write_y !== want.y ||
                        out_w.write_color !== want.color || out_w.last_write !== want.last) begin
                        if (o_fail_count < 10)
                            $display("mismatch exp %0d,%0d %h %b got %0d,%0d %h %b",
                                     want.x, want.y, want.color, want.last,
                                     out_w.write_x, out_w.write_y, out_w.write_color,
                                     out_w.last_write);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = pending_writes.size();
    end
endmodule

FILE: test/rotated_grid_pixel_writer_tb.sv
// testbench top: configures the grid, drives pixel items and gives the verdict
`timescale 1ns / 1ps
module rotated_grid_pixel_writer_tb;
    import rgpw_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    cycles = 0;
    int                    items_sent;
    int                    snd_idle_pct;
    int                    rcv_idle_pct;
    bit                    hold_go;
    logic                  hold_on;

    // shadow of the grid geometry, used only to aim items at the lines
    int g_ox, g_oy, g_ex, g_ey, g_cnt, g_t;

    rgpw_in_if  in_ch ();
    rgpw_out_if out_ch ();

    rotated_grid_pixel_writer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .in_ch      (in_ch.sink),
        .out_ch     (out_ch.source)
    );

    rgpw_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .in_w         (in_ch),
        .out_w        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_on) out_ch.ready <= 1'b0;
        else         out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // long receiver hold-off so the pipeline backs up into the input
    initial begin
        hold_on = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (500) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    task automatic cfg_write(t_reg_idx idx, logic [31:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic set_grid(int ox, int oy, int ex, int ey, int cnt, int t,
                            logic [31:0] rotation, logic [23:0] colour);
        cfg_write(REG_ORIGIN_X, ox);
        cfg_write(REG_ORIGIN_Y, oy);
        cfg_write(REG_EXTENT_X, ex);
        cfg_write(REG_EXTENT_Y, ey);
        cfg_write(REG_CELL_CNT, cnt);
        cfg_write(REG_THICKNESS, t);
        cfg_write(REG_ROTATION, rotation);
        cfg_write(REG_COLOR, 32'(colour));
        g_ox  = ox;
        g_oy  = oy;
        g_ex  = ex;
        g_ey  = ey;
        g_cnt = (cnt == 0) ? 1 : cnt;
        g_t   = t;
    endtask

    task automatic send_pixel(int x, int y);
        snd_idle_pct = (items_sent < 70) ? 8 : (items_sent < 140) ? 60 : 0;
        rcv_idle_pct = (items_sent < 70) ? 60 : (items_sent < 140) ? 8 : 0;
        while ($urandom_range(99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.pixel_x <= x[11:0];
        in_ch.pixel_y <= y[11:0];
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_random(int count);
        int pick, cell_sz, x, y;
        repeat (count) begin
            pick = $urandom_range(99);
            cell_sz = g_ex / g_cnt;
            if (cell_sz < 1) cell_sz = 1;
            x = g_ox + $urandom_range(g_ex + g_t);
            y = g_oy + $urandom_range(g_ey + g_t);
            if (pick < 40) begin
                x = g_ox + cell_sz * $urandom_range(g_cnt) + $urandom_range(g_t);
            end else if (pick < 75) begin
                cell_sz = g_ey / g_cnt;
                if (cell_sz < 1) cell_sz = 1;
                y = g_oy + cell_sz * $urandom_range(g_cnt) + $urandom_range(g_t);
            end else if (pick >= 88) begin
                x = $urandom_range(4095);
                y = $urandom_range(4095);
            end
            send_pixel(x, y);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        items_sent    = 0;
        snd_idle_pct  = 0;
        rcv_idle_pct  = 0;
        hold_go       = 1'b0;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = REG_ORIGIN_X;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.pixel_x = '0;
        in_ch.pixel_y = '0;
        g_ox = 0; g_oy = 0; g_ex = 256; g_ey = 256; g_cnt = 8; g_t = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, default grid: corners, centre, off-line and frame-edge cases
        send_pixel(0, 0);
        send_pixel(1, 1);
        send_pixel(2, 2);
        send_pixel(4095, 4095);
        send_pixel(0, 4095);
        send_pixel(4095, 0);
        send_pixel(256, 256);
        send_pixel(32, 100);
        send_pixel(100, 33);
        send_pixel(50, 50);
        send_pixel(128, 128);
        send_pixel(255, 64);
        drain();

        // zero cell count, extent below cell count, thin lines near the frame edge
        set_grid(1020, 1018, 3, 5, 0, 0, 32'h4000_0000, 24'h00_0000);
        send_pixel(1020, 1018);
        send_pixel(1022, 1022);
        send_pixel(1021, 1019);
        drain();
        set_grid(1000, 990, 3, 7, 9, 2, 32'h4000_0000, 24'h12_3456);
        send_pixel(1000, 990);
        send_pixel(1002, 996);
        send_pixel(1004, 998);
        drain();

        // large grid at the extremes of the origin, extent, thickness and colour registers
        set_grid(0, 0, 4095, 4095, 256, 255, 32'hC000_0000, 24'hFF_FFFF);
        send_pixel(4095, 4095);
        send_pixel(0, 0);
        send_pixel(2047, 2047);
        send_pixel(4094, 16);
        send_random(30);
        drain();

        set_grid(100, 200, 300, 200, 5, 3, {16'd11585, 16'd11585},
                 24'($urandom_range(24'hFF_FFFF)));
        hold_go = 1'b1;
        send_random(40);
        drain();

        set_grid(300, 300, 400, 400, 16, 0, {16'd0, 16'hC000},
                 24'($urandom_range(24'hFF_FFFF)));
        send_random(35);
        drain();

        set_grid(4095, 4095, 1, 1, 1, 255, 32'hFFFF_FFFF, 24'h80_0001);
        send_pixel(4095, 4095);
        send_pixel(0, 0);
        drain();

        set_grid($urandom_range(600), $urandom_range(600), 1 + $urandom_range(400),
                 1 + $urandom_range(400), 1 + $urandom_range(255), $urandom_range(12),
                 $urandom(), 24'($urandom_range(24'hFF_FFFF)));
        send_random(40);
        drain();

        set_grid(8, 8, 1000, 1000, 20, 4, {16'd15137, 16'hE782},
                 24'($urandom_range(24'hFF_FFFF)));
        send_random(15);
        drain();

        if (fail_count == 0) $display("Simulation PASSED");
        else                 $display("Simulation FAILED");
        $finish;
    end
endmodule
